// ----- rtl/plc_pkg.sv -----
// shared constants, codes and types for the positional list
`timescale 1ns / 1ps

package plc_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // fixed field widths of the stream words
    localparam int CMD_W       = 2;
    localparam int POS_W       = 7;
    localparam int VALUE_IN_W  = 32;
    localparam int STATUS_W    = 2;
    localparam int VALUE_OUT_W = 32;
    localparam int ITEM_CNT_W  = 7;

    localparam int IN_FIELDS_W  = CMD_W + POS_W + VALUE_IN_W;
    localparam int OUT_FIELDS_W = STATUS_W + VALUE_OUT_W + ITEM_CNT_W + 1;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // element count and the width used for position compares
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    // cells are gathered in groups for the removed-value tree
    localparam int GROUP      = 8;
    localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INS_BAD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REM_BAD = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [CMP_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] value;
    } ctrl_t;

endpackage

// ----- rtl/positional_list_insert_remove.sv -----
// an accepted word shifts the cells and fills the first tree level; in the drain state
// its result word is loaded onto m_tdata, and no new word is taken until that is done
// all cells shift in parallel in the cycle the word is accepted
// a result held back by m_tready lets one more word in, then the input waits
// reset (aresetn low, synchronous) empties the list and drops any pending result
// cell contents are not reset and are only read at occupied positions
`timescale 1ns / 1ps

module positional_list_insert_remove (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd[1:0], position[8:2], value_in[40:9], zero pad
    input  logic [plc_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], value_out[33:2], item_count[40:34], is_empty[41], zero pad
    output logic [plc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    logic [plc_pkg::COUNT_W-1:0]          count_reg;
    logic [plc_pkg::COUNT_W-1:0]          count_next;
    logic [plc_pkg::STATUS_W-1:0]         status_reg;
    logic [plc_pkg::STATUS_W-1:0]         status_next;
    logic                                 m_tvalid_reg;
    logic                                 m_tvalid_next;
    logic [plc_pkg::OUT_TDATA_W-1:0]      m_tdata_reg;
    logic [plc_pkg::OUT_TDATA_W-1:0]      m_tdata_next;
    logic                                 fresh_reg;
    logic [plc_pkg::DATA_WIDTH-1:0]       removed_reg;
    logic [plc_pkg::DATA_WIDTH-1:0]       removed_next;

    logic                                 accept;
    logic                                 load_out;
    logic [plc_pkg::CMD_W-1:0]            cmd;
    logic [plc_pkg::POS_W-1:0]            position;
    logic [plc_pkg::VALUE_IN_W-1:0]       value_in;
    logic [plc_pkg::CMP_W-1:0]            pos_c;
    logic [plc_pkg::CMP_W-1:0]            cnt_c;
    plc_pkg::ctrl_t                       ctrl;
    logic [plc_pkg::NUM_GROUPS-1:0][plc_pkg::DATA_WIDTH-1:0] group_hit;
    logic [plc_pkg::DATA_WIDTH-1:0]       removed;

    assign cmd      = s_tdata[1:0];
    assign position = s_tdata[8:2];
    assign value_in = s_tdata[40:9];
    assign pos_c    = plc_pkg::CMP_W'(position);
    assign cnt_c    = plc_pkg::CMP_W'(count_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_DRAIN) && (!m_tvalid_reg || m_tready);

    // request decode and count update
    always_comb begin
        ctrl.op     = plc_pkg::OP_NONE;
        ctrl.pos    = pos_c;
        ctrl.value  = plc_pkg::DATA_WIDTH'(value_in);
        status_next = status_reg;
        count_next  = count_reg;
        if (accept) begin
            status_next = plc_pkg::ST_OK;
            unique case (cmd)
                plc_pkg::CMD_INSERT: begin
                    if (pos_c > cnt_c) begin
                        status_next = plc_pkg::ST_INS_BAD;
                    end else if (count_reg == plc_pkg::COUNT_W'(plc_pkg::CAPACITY)) begin
                        status_next = plc_pkg::ST_FULL;
                    end else begin
                        ctrl.op    = plc_pkg::OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                plc_pkg::CMD_REMOVE: begin
                    if (pos_c >= cnt_c) begin
                        status_next = plc_pkg::ST_REM_BAD;
                    end else begin
                        ctrl.op    = plc_pkg::OP_REMOVE;
                        count_next = count_reg - 1'b1;
                    end
                end
                plc_pkg::CMD_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    plc_chain u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .group_hit (group_hit)
    );

    // second level of the removed-value tree
    always_comb begin
        removed = '0;
        for (int g = 0; g < plc_pkg::NUM_GROUPS; g++) begin
            removed = removed | group_hit[g];
        end
    end

    // the tree output is only valid in the first drain cycle, keep it while the output stalls
    assign removed_next = fresh_reg ? removed : removed_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (load_out) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = plc_pkg::OUT_TDATA_W'({
                        (count_reg == '0),
                        plc_pkg::ITEM_CNT_W'(count_reg),
                        plc_pkg::VALUE_OUT_W'(removed_next),
                        status_reg
                    });
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            fresh_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            fresh_reg    <= accept;
        end
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        removed_reg <= removed_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= plc_pkg::COUNT_W'(plc_pkg::CAPACITY))
        else $error("element count above capacity");

    a_accept_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_DRAIN)
        else $error("accepted word did not start a result");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DRAIN |-> !s_tready)
        else $error("input taken while a result is pending");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(state_reg == S_DRAIN) && state_reg == S_IDLE)
        |-> m_tvalid_reg)
        else $error("result lost on leaving drain");
`endif

endmodule

// ----- rtl/plc_cell.sv -----
// one list cell: holds an element and shifts with its neighbors
`timescale 1ns / 1ps

module plc_cell (
    input  logic                           aclk,
    input  plc_pkg::ctrl_t                 ctrl,
    input  logic [plc_pkg::CMP_W-1:0]      idx,
    input  logic [plc_pkg::DATA_WIDTH-1:0] prev_data,
    input  logic [plc_pkg::DATA_WIDTH-1:0] next_data,
    output logic [plc_pkg::DATA_WIDTH-1:0] data,
    output logic [plc_pkg::DATA_WIDTH-1:0] hit_data
);

    logic [plc_pkg::DATA_WIDTH-1:0] data_reg;
    logic [plc_pkg::DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            plc_pkg::OP_INSERT: begin
                if (idx > ctrl.pos) begin
                    data_next = prev_data;
                end else if (idx == ctrl.pos) begin
                    data_next = ctrl.value;
                end
            end
            plc_pkg::OP_REMOVE: begin
                if (idx >= ctrl.pos) begin
                    data_next = next_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // old contents of the cell being removed, zero elsewhere
    assign hit_data = (ctrl.op == plc_pkg::OP_REMOVE && idx == ctrl.pos) ? data_reg : '0;

endmodule

// ----- rtl/plc_chain.sv -----
// row of list cells plus the first registered level of the removed-value tree
`timescale 1ns / 1ps

module plc_chain (
    input  logic                           aclk,
    input  plc_pkg::ctrl_t                 ctrl,
    output logic [plc_pkg::NUM_GROUPS-1:0][plc_pkg::DATA_WIDTH-1:0] group_hit
);

    logic [plc_pkg::DATA_WIDTH-1:0] data_w [plc_pkg::CAPACITY];
    logic [plc_pkg::DATA_WIDTH-1:0] hit_w  [plc_pkg::CAPACITY];

    logic [plc_pkg::NUM_GROUPS-1:0][plc_pkg::DATA_WIDTH-1:0] group_reg;
    logic [plc_pkg::NUM_GROUPS-1:0][plc_pkg::DATA_WIDTH-1:0] group_next;

    for (genvar k = 0; k < plc_pkg::CAPACITY; k++) begin : g_cell
        logic [plc_pkg::DATA_WIDTH-1:0] prev_w;
        logic [plc_pkg::DATA_WIDTH-1:0] next_w;

        if (k == 0) begin : g_head
            assign prev_w = '0;
        end else begin : g_mid_prev
            assign prev_w = data_w[k-1];
        end

        if (k == plc_pkg::CAPACITY - 1) begin : g_tail
            assign next_w = '0;
        end else begin : g_mid_next
            assign next_w = data_w[k+1];
        end

        plc_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .idx       (plc_pkg::CMP_W'(k)),
            .prev_data (prev_w),
            .next_data (next_w),
            .data      (data_w[k]),
            .hit_data  (hit_w[k])
        );
    end

    // at most one cell hits, so an or per group selects it
    always_comb begin
        for (int g = 0; g < plc_pkg::NUM_GROUPS; g++) begin
            group_next[g] = '0;
            for (int j = 0; j < plc_pkg::GROUP; j++) begin
                if (g * plc_pkg::GROUP + j < plc_pkg::CAPACITY) begin
                    group_next[g] = group_next[g] | hit_w[g * plc_pkg::GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        group_reg <= group_next;
    end

    assign group_hit = group_reg;

endmodule
